// File: hdl/lctr_pkg.sv
// Shared types and constants for the LC-trie route lookup block.
// Used by lctr_walk and lc_trie_route_lookup_top; no dependencies.
package lctr_pkg;

    // Table sizes
    localparam int NODE_ENTRIES = 128;
    localparam int HOP_ENTRIES  = 16;
    localparam int HOP_WIDTH    = 16;

    localparam int NODE_AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
    localparam int HOP_AW  = (HOP_ENTRIES > 1) ? $clog2(HOP_ENTRIES) : 1;

    // Node word layout
    localparam int BRANCH_LSB = 27;
    localparam int SKIP_LSB   = 22;
    localparam int FIELD_W    = 5;
    localparam int ADDR_W     = 22;
    localparam int IP_BITS    = 32;
    localparam int POS_W      = 6;

    typedef enum logic [1:0] {
        KIND_NODE_WR = 2'd0,
        KIND_HOP_WR  = 2'd1,
        KIND_LOOKUP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODE,
        ST_HOP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  entry_index;
        logic [31:0] entry_word;
        logic [31:0] ip_address;
    } t_req;

    typedef struct packed {
        logic [15:0] next_hop;
        logic        fault;
    } t_rsp;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic [31:0]        wdata;
        logic               re;
        logic [NODE_AW-1:0] raddr;
    } t_node_cmd;

    typedef struct packed {
        logic                 we;
        logic [HOP_AW-1:0]    waddr;
        logic [HOP_WIDTH-1:0] wdata;
        logic                 re;
        logic [HOP_AW-1:0]    raddr;
    } t_hop_cmd;

    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_walk_res;

endpackage

// File: hdl/lctr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module lctr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lctr_walk.sv
// Request decoder and trie walk sequencer: issues table writes and walks the trie
// one node read per level. Depends on lctr_pkg.
module lctr_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  lctr_pkg::t_req                      i_req,
    output logic                                o_req_stall,
    output lctr_pkg::t_node_cmd                 o_node,
    input  logic [31:0]                         i_node_rdata,
    output lctr_pkg::t_hop_cmd                  o_hop,
    input  logic [lctr_pkg::HOP_WIDTH-1:0]      i_hop_rdata,
    output lctr_pkg::t_walk_res                 o_res,
    input  logic                                i_res_ready
);

    lctr_pkg::t_state r_state, n_state;
    logic [31:0]                  r_ip, n_ip;
    logic [lctr_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [15:0]                  r_hop, n_hop;
    logic                         r_fault, n_fault;

    logic                         req_take;
    logic [lctr_pkg::FIELD_W-1:0] nd_branch;
    logic [lctr_pkg::FIELD_W-1:0] nd_skip;
    logic [lctr_pkg::ADDR_W-1:0]  nd_addr;
    logic [lctr_pkg::POS_W-1:0]   pos_cur;
    logic [lctr_pkg::POS_W:0]     pos_end;
    logic [31:0]                  ip_shl;
    logic [31:0]                  ip_bits;
    logic [32:0]                  child_idx;
    logic                         past_end;
    logic                         child_ok;
    logic                         leaf_ok;

    assign req_take = i_req_valid && (r_state == lctr_pkg::ST_IDLE);

    // Node word fields and one level of the walk
    assign nd_branch = i_node_rdata[lctr_pkg::BRANCH_LSB +: lctr_pkg::FIELD_W];
    assign nd_skip   = i_node_rdata[lctr_pkg::SKIP_LSB +: lctr_pkg::FIELD_W];
    assign nd_addr   = i_node_rdata[lctr_pkg::ADDR_W-1:0];
    assign pos_cur   = r_pos + lctr_pkg::POS_W'(nd_skip);
    assign pos_end   = (lctr_pkg::POS_W+1)'(pos_cur) + (lctr_pkg::POS_W+1)'(nd_branch);
    assign past_end  = pos_end > (lctr_pkg::POS_W+1)'(lctr_pkg::IP_BITS);
    assign ip_shl    = r_ip << pos_cur;
    assign ip_bits   = ip_shl >> (lctr_pkg::POS_W'(lctr_pkg::IP_BITS)
                                  - lctr_pkg::POS_W'(nd_branch));
    assign child_idx = 33'(nd_addr) + 33'(ip_bits);
    assign child_ok  = child_idx < 33'(lctr_pkg::NODE_ENTRIES);
    assign leaf_ok   = 33'(nd_addr) < 33'(lctr_pkg::HOP_ENTRIES);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lctr_pkg::ST_IDLE: begin
                if (req_take && i_req.kind == lctr_pkg::KIND_LOOKUP) begin
                    n_state = lctr_pkg::ST_NODE;
                end
            end
            lctr_pkg::ST_NODE: begin
                if (nd_branch == '0) begin
                    n_state = leaf_ok ? lctr_pkg::ST_HOP : lctr_pkg::ST_RESULT;
                end else if (past_end || !child_ok) begin
                    n_state = lctr_pkg::ST_RESULT;
                end
            end
            lctr_pkg::ST_HOP: begin
                n_state = lctr_pkg::ST_RESULT;
            end
            lctr_pkg::ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = lctr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lctr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_ip    = r_ip;
        n_pos   = r_pos;
        n_hop   = r_hop;
        n_fault = r_fault;
        o_node  = '0;
        o_hop   = '0;
        o_node.waddr = lctr_pkg::NODE_AW'(i_req.entry_index);
        o_node.wdata = i_req.entry_word;
        o_hop.waddr  = lctr_pkg::HOP_AW'(i_req.entry_index);
        o_hop.wdata  = lctr_pkg::HOP_WIDTH'(i_req.entry_word);
        o_hop.raddr  = lctr_pkg::HOP_AW'(nd_addr);
        o_req_stall  = (r_state != lctr_pkg::ST_IDLE);
        o_res.valid  = (r_state == lctr_pkg::ST_RESULT);
        o_res.rsp.next_hop = r_hop;
        o_res.rsp.fault    = r_fault;
        case (r_state)
            lctr_pkg::ST_IDLE: begin
                if (req_take) begin
                    case (i_req.kind)
                        lctr_pkg::KIND_NODE_WR: begin
                            o_node.we = 32'(i_req.entry_index) < 32'(lctr_pkg::NODE_ENTRIES);
                        end
                        lctr_pkg::KIND_HOP_WR: begin
                            o_hop.we = 32'(i_req.entry_index) < 32'(lctr_pkg::HOP_ENTRIES);
                        end
                        lctr_pkg::KIND_LOOKUP: begin
                            // Start at the root
                            o_node.re    = 1'b1;
                            o_node.raddr = '0;
                            n_ip         = i_req.ip_address;
                            n_pos        = '0;
                        end
                        default: begin
                            // Drop the unused kind
                        end
                    endcase
                end
            end
            lctr_pkg::ST_NODE: begin
                if (nd_branch == '0) begin
                    if (leaf_ok) begin
                        o_hop.re = 1'b1;
                    end else begin
                        n_hop   = '0;
                        n_fault = 1'b1;
                    end
                end else if (past_end || !child_ok) begin
                    n_hop   = '0;
                    n_fault = 1'b1;
                end else begin
                    // Advance to the child
                    o_node.re    = 1'b1;
                    o_node.raddr = lctr_pkg::NODE_AW'(child_idx);
                    n_pos        = lctr_pkg::POS_W'(pos_end);
                end
            end
            lctr_pkg::ST_HOP: begin
                n_hop   = 16'(i_hop_rdata);
                n_fault = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lctr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ip    <= n_ip;
        r_pos   <= n_pos;
        r_hop   <= n_hop;
        r_fault <= n_fault;
    end

`ifndef SYNTHESIS
    a_lookup_reads_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && i_req.kind == lctr_pkg::KIND_LOOKUP) |=> (r_state == lctr_pkg::ST_NODE))
        else $error("lookup did not start the walk");
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lctr_pkg::ST_NODE) |-> (r_pos <= lctr_pkg::POS_W'(lctr_pkg::IP_BITS)))
        else $error("bit position ran past the address");
    a_hop_after_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lctr_pkg::ST_HOP) |-> ($past(r_state) == lctr_pkg::ST_NODE))
        else $error("next hop read without a leaf");
    a_node_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_node.we && o_node.re))
        else $error("node memory written and read in one cycle");
`endif

endmodule

// File: hdl/lc_trie_route_lookup_top.sv
// Top level of the LC-trie route lookup: node and next-hop memories, walk
// sequencer and response register. Depends on lctr_pkg, lctr_ram, lctr_walk.
//
// The block takes one request at a time. A node write or next-hop write
// is performed when the request is taken and returns nothing; writes beyond a
// table and the unused request kind are dropped. A lookup reads node 0, then
// one node word per trie level from the node memory (one read port,
// registered read), then one next-hop entry. A walk that would extract bits
// past the 32 address bits, index a child beyond the node table or select a
// leaf beyond the next-hop table returns fault 1 with next hop 0. The
// response sits in an output register, so a new request is taken while an
// earlier response still waits; a finished lookup holds its result until
// that register frees up. Both tables power up undefined and must be
// written before a lookup touches them.
module lc_trie_route_lookup_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  lctr_pkg::t_req i_req,
    output logic           o_req_stall,
    output logic           o_rsp_valid,
    output lctr_pkg::t_rsp o_rsp,
    input  logic           i_rsp_stall
);

    lctr_pkg::t_node_cmd             node_cmd;
    lctr_pkg::t_hop_cmd              hop_cmd;
    lctr_pkg::t_walk_res             walk_res;
    logic [31:0]                     node_rdata;
    logic [lctr_pkg::HOP_WIDTH-1:0]  hop_rdata;
    logic                            res_ready;

    logic           r_rsp_valid, n_rsp_valid;
    lctr_pkg::t_rsp r_rsp, n_rsp;

    // Trie node memory
    lctr_ram #(
        .WIDTH (32),
        .DEPTH (lctr_pkg::NODE_ENTRIES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_cmd.we),
        .i_waddr (node_cmd.waddr),
        .i_wdata (node_cmd.wdata),
        .i_re    (node_cmd.re),
        .i_raddr (node_cmd.raddr),
        .o_rdata (node_rdata)
    );

    // Next-hop memory
    lctr_ram #(
        .WIDTH (lctr_pkg::HOP_WIDTH),
        .DEPTH (lctr_pkg::HOP_ENTRIES)
    ) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (hop_cmd.we),
        .i_waddr (hop_cmd.waddr),
        .i_wdata (hop_cmd.wdata),
        .i_re    (hop_cmd.re),
        .i_raddr (hop_cmd.raddr),
        .o_rdata (hop_rdata)
    );

    lctr_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req        (i_req),
        .o_req_stall  (o_req_stall),
        .o_node       (node_cmd),
        .i_node_rdata (node_rdata),
        .o_hop        (hop_cmd),
        .i_hop_rdata  (hop_rdata),
        .o_res        (walk_res),
        .i_res_ready  (res_ready)
    );

    // Response register: load when empty or being drained this cycle
    assign res_ready = !r_rsp_valid || !i_rsp_stall;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (walk_res.valid && res_ready) begin
            n_rsp_valid = 1'b1;
            n_rsp       = walk_res.rsp;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
